/* design/entity_owner_hash_map_defines.svh */
// Assertion macros for the entity owner hash map.
`ifndef ENTITY_OWNER_HASH_MAP_DEFINES_SVH
`define ENTITY_OWNER_HASH_MAP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define EOHM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define EOHM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/eohm_pkg.sv */
// Shared constants, status codes and types for the entity owner hash map.
package eohm_pkg;

   localparam int TABLE_SLOTS_DEF = 64;
   localparam int MAX_ENTRIES_DEF = 32;

   localparam int KeyW   = 64;
   localparam int OwnerW = 64;
   localparam int StatW  = 2;

   // FNV prime 2^40 + 0x1b3, split into a shift and a short factor
   localparam logic [KeyW-1:0] HashBasis = 64'hcbf2_9ce4_8422_2325;
   localparam logic [8:0]      HashPrimeLow = 9'h1b3;
   localparam int              HashPrimeShift = 40;

   // hash folding for slot counts that are not a power of two
   localparam int FoldBits  = 8;
   localparam int FoldSteps = KeyW / FoldBits;
   localparam int FoldCntW  = $clog2(FoldSteps);

   localparam logic [StatW-1:0] StatusOk      = 2'd0;
   localparam logic [StatW-1:0] StatusAbsent  = 2'd1;
   localparam logic [StatW-1:0] StatusFull    = 2'd2;
   localparam logic [StatW-1:0] StatusInvalid = 2'd3;

   typedef struct packed {
      logic              en;
      logic [KeyW-1:0]   key;
      logic [OwnerW-1:0] owner;
   } slot_wr_type;

endpackage

/* design/eohm_slot_store.sv */
// Slot memory: keys and owners, one write port and one registered read port.
module eohm_slot_store
   import eohm_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int IDX_W = $clog2(TABLE_SLOTS)
) (
   input  logic              clock,
   input  slot_wr_type       wr,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [KeyW-1:0]   rd_key,
   output logic [OwnerW-1:0] rd_owner
);

   logic [KeyW-1:0]   key_mem   [TABLE_SLOTS];
   logic [OwnerW-1:0] owner_mem [TABLE_SLOTS];
   logic [KeyW-1:0]   rd_key_ff;
   logic [OwnerW-1:0] rd_owner_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr_addr]   <= wr.key;
         owner_mem[wr_addr] <= wr.owner;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_owner_ff <= owner_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_owner = rd_owner_ff;

endmodule

/* design/entity_owner_hash_map.sv */
// Steps: an accepted request passes ST_MUL, ST_ADD, ST_MOD (repeated once per fold step when
//   TABLE_SLOTS is not a power of two), ST_PROBE and ST_RESP; an invalid key goes to ST_RESP.
// Requests: none is taken until the last response is issued; the probe walks one slot per cycle
//   through the single read port of the slot memory.
// Reset: synchronous; a clearing pass over every slot follows, with req_tready low.
`include "entity_owner_hash_map_defines.svh"

module entity_owner_hash_map
   import eohm_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // entity_key[63:0], owner_value[127:64]
   input  logic         req_tuser,   // kind[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata    // owner_found[63:0], status[65:64], zero[71:66]
);

   localparam int IdxW = $clog2(TABLE_SLOTS);
   localparam int RemW = IdxW + 1;
   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam bit SlotsPow2 = ((1 << IdxW) == TABLE_SLOTS);
   localparam logic [IdxW-1:0] LastSlot = IdxW'(TABLE_SLOTS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_MOD   = 3'd4;
   localparam logic [2:0] ST_PROBE = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [IdxW-1:0]     pos_ff, pos_in;
   logic [IdxW-1:0]     steps_ff, steps_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [FoldCntW-1:0] fold_ff, fold_in;
   logic [RemW-1:0]     rem_ff, rem_in;
   logic                kind_ff, kind_in;
   logic [KeyW-1:0]     key_ff, key_in;
   logic [OwnerW-1:0]   owner_ff, owner_in;
   logic [KeyW-1:0]     x_ff, x_in;
   logic [KeyW-1:0]     prod_ff, prod_in;
   logic [KeyW-1:0]     hash_ff, hash_in;
   logic [OwnerW-1:0]   res_owner_ff, res_owner_in;
   logic [StatW-1:0]    res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OwnerW-1:0]   rsp_owner_ff, rsp_owner_in;
   logic [StatW-1:0]    rsp_status_ff, rsp_status_in;

   slot_wr_type         wr;
   logic [KeyW-1:0]     rd_key;
   logic [OwnerW-1:0]   rd_owner;
   logic                hit;
   logic                empty;
   logic [RemW-1:0]     rem_step;
   logic [IdxW-1:0]     pos_next;

   eohm_slot_store #(
      .TABLE_SLOTS(TABLE_SLOTS),
      .IDX_W(IdxW)
   ) u_store (
      .clock(clock),
      .wr(wr),
      .wr_addr(pos_ff),
      .rd_addr(pos_in),
      .rd_key(rd_key),
      .rd_owner(rd_owner)
   );

   assign hit      = (rd_key == key_ff);
   assign empty    = (rd_key == '0);
   assign pos_next = (pos_ff == LastSlot) ? '0 : pos_ff + 1'b1;

   always_comb begin
      rem_step = rem_ff;
      for (int i = 0; i < FoldBits; i++) begin
         rem_step = {rem_step[IdxW-1:0], hash_ff[KeyW-1-i]};
         if (rem_step >= RemW'(TABLE_SLOTS)) begin
            rem_step = rem_step - RemW'(TABLE_SLOTS);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      fold_in       = fold_ff;
      rem_in        = rem_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      owner_in      = owner_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      hash_in       = hash_ff;
      res_owner_in  = res_owner_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_status_in = rsp_status_ff;
      wr            = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr.en  = 1'b1;
            pos_in = pos_next;
            if (pos_ff == LastSlot) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in      = req_tuser;
               key_in       = req_tdata[63:0];
               owner_in     = req_tdata[127:64];
               x_in         = HashBasis ^ req_tdata[63:0];
               res_owner_in = '0;
               if (req_tdata[63:0] == '0) begin
                  res_status_in = StatusInvalid;
                  state_in      = ST_RESP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = KeyW'(x_ff * {{(KeyW-9){1'b0}}, HashPrimeLow});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            hash_in  = prod_ff + (x_ff << HashPrimeShift);
            rem_in   = '0;
            fold_in  = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            steps_in = '0;
            if (SlotsPow2) begin
               pos_in   = hash_ff[IdxW-1:0];
               state_in = ST_PROBE;
            end else begin
               rem_in  = rem_step;
               hash_in = hash_ff << FoldBits;
               fold_in = fold_ff + 1'b1;
               if (fold_ff == FoldCntW'(FoldSteps - 1)) begin
                  pos_in   = rem_step[IdxW-1:0];
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            pos_in   = pos_next;
            steps_in = steps_ff + 1'b1;
            if (hit) begin
               state_in      = ST_RESP;
               res_status_in = StatusOk;
               if (!kind_ff) begin
                  res_owner_in = rd_owner;
               end else if (owner_ff == '0) begin
                  wr.en = 1'b1;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  wr.en    = 1'b1;
                  wr.key   = key_ff;
                  wr.owner = owner_ff;
               end
            end else if (empty || steps_ff == LastSlot) begin
               state_in = ST_RESP;
               if (!kind_ff || owner_ff == '0) begin
                  res_status_in = StatusAbsent;
               end else if (!empty || count_ff >= CntW'(MAX_ENTRIES)) begin
                  res_status_in = StatusFull;
               end else begin
                  res_status_in = StatusOk;
                  wr.en         = 1'b1;
                  wr.key        = key_ff;
                  wr.owner      = owner_ff;
                  count_in      = count_ff + 1'b1;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_owner_in  = res_owner_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      fold_ff       <= fold_in;
      rem_ff        <= rem_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      owner_ff      <= owner_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      hash_ff       <= hash_in;
      res_owner_ff  <= res_owner_in;
      res_status_ff <= res_status_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_owner_ff};

   `EOHM_ASSERT_IMP(a_count_max, 1'b1, count_ff <= CntW'(MAX_ENTRIES),
      "entry count above limit")
   `EOHM_ASSERT_IMP(a_write_ok, wr.en,
      (state_ff == ST_CLEAR) || (state_ff == ST_PROBE && res_status_in == StatusOk),
      "slot write without ok status")
   `EOHM_ASSERT_NXT(a_insert_count, state_ff == ST_PROBE && wr.en && empty,
      count_ff == $past(count_ff) + 1'b1, "insert did not count entry")
   `EOHM_ASSERT_IMP(a_invalid_key, state_ff == ST_RESP && res_status_ff == StatusInvalid,
      key_ff == '0, "invalid status for nonzero key")

endmodule
